@@ design/lrpf_pkg.sv @@
// shared types, widths and constants for the log repulsion pair force core
// no dependencies; all design files but lrpf_delay refer to it by scoped names
`default_nettype none

package lrpf_pkg;

    // field widths
    localparam int DELTA_W    = 24;
    localparam int RADIUS_W   = 20;
    localparam int FORCE_W    = 32;
    localparam int STRENGTH_W = 24;
    localparam int MAX_DIM    = 3;
    localparam int DIM_DEFAULT = 3;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 24'd983040;
    localparam int STRENGTH_FRAC = 16;

    // datapath widths
    localparam int REST_W = RADIUS_W + 1;
    localparam int MAG_W  = DELTA_W;
    // magnitudes are at most 2^(DELTA_W-1), so three squares fit in 2*MAG_W bits
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D2_W   = 2 * MAG_W;
    localparam int R2_W   = 2 * REST_W;
    localparam int ROOT_W = D2_W / 2;

    localparam int LG_FRAC = 24;
    localparam int LG_P_W  = $clog2(D2_W);
    localparam int LG_W    = LG_P_W + LG_FRAC;
    localparam int LG_M_W  = 31;

    localparam int LN2_W = 32;
    localparam logic [LN2_W-1:0] LN2_HALF = 32'd1488522236;

    localparam int PL_W   = LG_W + LN2_W;
    localparam int L_W    = 29;
    localparam int PG_W   = REST_W + L_W;
    localparam int G_W    = 26;
    localparam int PH_W   = G_W + STRENGTH_W;
    localparam int H_W    = 34;
    localparam int U_FRAC = 24;
    localparam int U_W    = U_FRAC + 1;
    localparam int PLO_W  = FORCE_W + U_W;
    localparam int PHI_W  = (H_W - FORCE_W) + U_W;
    localparam int MS_W   = H_W + U_W + 1;
    localparam int UMAG_W = MS_W - U_FRAC;

    typedef enum logic [1:0] {
        ST_NO_OVERLAP = 2'd0,
        ST_REPULSION  = 2'd1,
        ST_COINCIDENT = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_z;
        logic [RADIUS_W-1:0]       radius_a;
        logic [RADIUS_W-1:0]       radius_b;
    } t_pair_req;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        t_status                   contact_status;
    } t_pair_force;

    typedef struct packed {
        logic no_overlap;
        logic coincident;
    } t_contact_flags;

endpackage

`default_nettype wire

@@ design/lrpf_delay.sv @@
// stalling delay line that keeps side data aligned with the main pipeline
// no dependencies
`default_nettype none

module lrpf_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

@@ design/lrpf_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// uses lrpf_pkg for the default radicand width
`default_nettype none

module lrpf_isqrt #(
    parameter int IN_W = lrpf_pkg::D2_W
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_rad,
    output logic [IN_W/2-1:0] o_root
);

    localparam int STEPS = IN_W / 2;
    localparam int RW    = STEPS + 2;

    logic [RW-1:0]    r_rem  [STEPS];
    logic [STEPS-1:0] r_root [STEPS];
    logic [IN_W-1:0]  r_rad  [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [RW-1:0]    w_rem;
        logic [STEPS-1:0] w_root;
        logic [IN_W-1:0]  w_rad;
        logic [RW-1:0]    w_cat;
        logic [RW-1:0]    w_trial;

        if (s == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
            assign w_rad  = r_rad[s-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_cat   = {w_rem[RW-3:0], w_rad[IN_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cat >= w_trial) begin
                    r_rem[s]  <= w_cat - w_trial;
                    r_root[s] <= {w_root[STEPS-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= w_cat;
                    r_root[s] <= {w_root[STEPS-2:0], 1'b0};
                end
                r_rad[s] <= w_rad << 2;
            end
        end
    end

    assign o_root = r_root[STEPS-1];

endmodule

`default_nettype wire

@@ design/lrpf_log2.sv @@
// pipelined base-2 logarithm: leading-zero normalize, then one squaring per fraction bit
// uses lrpf_pkg for default widths and the mantissa width
`default_nettype none

module lrpf_log2 #(
    parameter int IN_W = lrpf_pkg::D2_W,
    parameter int FRAC = lrpf_pkg::LG_FRAC
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [IN_W-1:0]               i_val,
    output logic [$clog2(IN_W)+FRAC-1:0]  o_lg
);

    localparam int P_W = $clog2(IN_W);
    localparam int NS  = P_W;
    localparam int M_W = lrpf_pkg::LG_M_W;

    logic [IN_W-1:0] r_nv [NS];
    logic [P_W-1:0]  r_lz [NS];

    // normalize in halving shift steps
    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - s);
        logic [IN_W-1:0] w_v;
        logic [P_W-1:0]  w_lz;

        if (s == 0) begin : g_first
            assign w_v  = i_val;
            assign w_lz = '0;
        end else begin : g_next
            assign w_v  = r_nv[s-1];
            assign w_lz = r_lz[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v[IN_W-1 -: SH] == '0) begin
                    r_nv[s] <= w_v << SH;
                    r_lz[s] <= w_lz + P_W'(SH);
                end else begin
                    r_nv[s] <= w_v;
                    r_lz[s] <= w_lz;
                end
            end
        end
    end

    logic [M_W-1:0]  r_m [FRAC];
    logic [FRAC-1:0] r_f [FRAC];
    logic [P_W-1:0]  r_p [FRAC];

    // fraction bits by repeated squaring of the mantissa in [1,2)
    for (genvar f = 0; f < FRAC; f++) begin : g_frac
        logic [M_W-1:0]   w_m;
        logic [FRAC-1:0]  w_f;
        logic [P_W-1:0]   w_p;
        logic [2*M_W-1:0] w_sq;
        logic [M_W:0]     w_t;

        if (f == 0) begin : g_first
            assign w_m = r_nv[NS-1][IN_W-1 -: M_W];
            assign w_f = '0;
            assign w_p = P_W'(IN_W - 1) - r_lz[NS-1];
        end else begin : g_next
            assign w_m = r_m[f-1];
            assign w_f = r_f[f-1];
            assign w_p = r_p[f-1];
        end

        assign w_sq = (2*M_W)'(w_m) * (2*M_W)'(w_m);
        assign w_t  = w_sq[2*M_W-1 : M_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_t[M_W]) begin
                    r_m[f] <= w_t[M_W:1];
                    r_f[f] <= {w_f[FRAC-2:0], 1'b1};
                end else begin
                    r_m[f] <= w_t[M_W-1:0];
                    r_f[f] <= {w_f[FRAC-2:0], 1'b0};
                end
                r_p[f] <= w_p;
            end
        end
    end

    assign o_lg = {r_p[FRAC-1], r_f[FRAC-1]};

endmodule

`default_nettype wire

@@ design/lrpf_div.sv @@
// pipelined restoring divider for (num << SH) / den, one quotient bit per stage
// uses lrpf_pkg for default widths; the quotient must fit in Q_W bits
`default_nettype none

module lrpf_div #(
    parameter int N_W = lrpf_pkg::MAG_W,
    parameter int D_W = lrpf_pkg::ROOT_W,
    parameter int Q_W = lrpf_pkg::U_W,
    parameter int SH  = lrpf_pkg::U_FRAC
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);

    localparam int DV_W = N_W + SH;

    logic [DV_W-1:0] w_dividend;
    assign w_dividend = {i_num, {SH{1'b0}}};

    logic [D_W-1:0] r_r   [Q_W];
    logic [Q_W-1:0] r_low [Q_W];
    logic [D_W-1:0] r_d   [Q_W];
    logic [Q_W-1:0] r_q   [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_step
        logic [D_W-1:0] w_r;
        logic [Q_W-1:0] w_low;
        logic [D_W-1:0] w_d;
        logic [Q_W-1:0] w_q;
        logic [D_W:0]   w_cat;

        if (s == 0) begin : g_first
            // upper dividend bits start below the divisor when the quotient fits
            assign w_r   = D_W'(w_dividend >> Q_W);
            assign w_low = w_dividend[Q_W-1:0];
            assign w_d   = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_r   = r_r[s-1];
            assign w_low = r_low[s-1];
            assign w_d   = r_d[s-1];
            assign w_q   = r_q[s-1];
        end

        assign w_cat = {w_r, w_low[Q_W-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cat >= {1'b0, w_d}) begin
                    r_r[s] <= D_W'(w_cat - {1'b0, w_d});
                    r_q[s] <= {w_q[Q_W-2:0], 1'b1};
                end else begin
                    r_r[s] <= w_cat[D_W-1:0];
                    r_q[s] <= {w_q[Q_W-2:0], 1'b0};
                end
                r_low[s] <= w_low << 1;
                r_d[s]   <= w_d;
            end
        end
    end

    assign o_quo = r_q[Q_W-1];

endmodule

`default_nettype wire

@@ design/log_repulsion_pair_force_core.sv @@
// top level of the log repulsion pair force core
// uses lrpf_pkg, lrpf_delay, lrpf_isqrt, lrpf_log2 and lrpf_div
`default_nettype none

// Takes one pair request per clock (vector A->B in signed Q8.16, two radii in
// unsigned Q4.16) and returns the repulsive force on A in signed Q16.16 with a
// contact status, in request order. The datapath is a 54 stage pipeline with
// an output register behind it; the pipeline length comes from the 24 stage
// square root feeding the 25 stage per-axis divider, with the two 30 stage
// logarithm units and the force scaling running alongside. Throughput is one
// request per cycle while the skid register is empty. A one-entry skid
// register behind the output register absorbs a stall; while it is full the
// whole pipeline and the request side hold. The strength register may only be
// written while no request is in flight.

module log_repulsion_pair_force_core #(
    parameter int DIMENSIONS = lrpf_pkg::DIM_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pair requests
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  lrpf_pkg::t_pair_req                  i_req,
    // force results
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output lrpf_pkg::t_pair_force                o_rsp,
    // strength register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lrpf_pkg::STRENGTH_W-1:0]      i_cfg_data
);

    localparam int NL = lrpf_pkg::MAX_DIM;

    // stage numbers at which each value sits in a register
    localparam int ST_D2   = 3;
    localparam int ST_ROOT = ST_D2 + lrpf_pkg::ROOT_W;
    localparam int ST_LG   = ST_D2 + lrpf_pkg::LG_P_W + lrpf_pkg::LG_FRAC;
    localparam int ST_L    = ST_LG + 3;
    localparam int ST_H    = ST_L + 4;
    localparam int ST_U    = ST_ROOT + lrpf_pkg::U_W;
    localparam int ST_MAG  = ST_U + 2;
    localparam int NSTG    = ST_MAG;

    // strength register
    logic [lrpf_pkg::STRENGTH_W-1:0] r_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= lrpf_pkg::STRENGTH_RESET;
        end else if (i_cfg_valid) begin
            r_strength <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // the pipeline moves whenever the skid register is free
    logic r_skid_v;
    logic w_en;
    assign w_en        = !r_skid_v;
    assign o_req_ready = w_en;

    logic [NSTG-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NSTG-2:0], i_req_valid};
        end
    end

    // stage 1: magnitudes, signs and rest length
    logic signed [lrpf_pkg::DELTA_W-1:0] w_delta [NL];
    assign w_delta[0] = i_req.delta_x;
    assign w_delta[1] = i_req.delta_y;
    assign w_delta[2] = i_req.delta_z;

    logic [lrpf_pkg::MAG_W-1:0]  r1_mg [NL];
    logic [NL-1:0]               r1_neg;
    logic [lrpf_pkg::REST_W-1:0] r1_rest;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                if (i < DIMENSIONS) begin
                    r1_neg[i] <= w_delta[i][lrpf_pkg::DELTA_W-1];
                    r1_mg[i]  <= w_delta[i][lrpf_pkg::DELTA_W-1] ?
                                 lrpf_pkg::MAG_W'(~w_delta[i] + 1'b1) :
                                 lrpf_pkg::MAG_W'(w_delta[i]);
                end else begin
                    // unused axis acts as a zero component
                    r1_neg[i] <= 1'b0;
                    r1_mg[i]  <= '0;
                end
            end
            r1_rest <= lrpf_pkg::REST_W'(i_req.radius_a) + lrpf_pkg::REST_W'(i_req.radius_b);
        end
    end

    // stage 2: squares
    logic [lrpf_pkg::SQ_W-1:0] r2_sq [NL];
    logic [lrpf_pkg::R2_W-1:0] r2_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r2_sq[i] <= lrpf_pkg::SQ_W'(r1_mg[i]) * lrpf_pkg::SQ_W'(r1_mg[i]);
            end
            r2_r2 <= lrpf_pkg::R2_W'(r1_rest) * lrpf_pkg::R2_W'(r1_rest);
        end
    end

    // stage 3: squared distance
    logic [lrpf_pkg::D2_W-1:0] r3_d2;
    logic [lrpf_pkg::D2_W-1:0] r3_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_d2 <= lrpf_pkg::D2_W'(r2_sq[0]) + lrpf_pkg::D2_W'(r2_sq[1]) +
                     lrpf_pkg::D2_W'(r2_sq[2]);
            r3_r2 <= lrpf_pkg::D2_W'(r2_r2);
        end
    end

    // stage 4: overlap and coincidence, carried to the end
    lrpf_pkg::t_contact_flags r4_flags;
    lrpf_pkg::t_contact_flags w_flags_end;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_flags.no_overlap <= (r3_d2 >= r3_r2);
            r4_flags.coincident <= (r3_d2 == '0);
        end
    end

    lrpf_delay #(
        .W     ($bits(lrpf_pkg::t_contact_flags)),
        .DEPTH (ST_MAG - 4)
    ) u_flags_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r4_flags),
        .o_data (w_flags_end)
    );

    // distance
    logic [lrpf_pkg::ROOT_W-1:0] w_root;

    lrpf_isqrt #(
        .IN_W (lrpf_pkg::D2_W)
    ) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r3_d2),
        .o_root (w_root)
    );

    // log2 of both squared lengths
    logic [lrpf_pkg::LG_W-1:0] w_lg_d;
    logic [lrpf_pkg::LG_W-1:0] w_lg_r;

    lrpf_log2 #(
        .IN_W (lrpf_pkg::D2_W),
        .FRAC (lrpf_pkg::LG_FRAC)
    ) u_lg_dist (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val (r3_d2),
        .o_lg  (w_lg_d)
    );

    lrpf_log2 #(
        .IN_W (lrpf_pkg::D2_W),
        .FRAC (lrpf_pkg::LG_FRAC)
    ) u_lg_rest (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_val (r3_r2),
        .o_lg  (w_lg_r)
    );

    // rest length waits for the log result
    logic [lrpf_pkg::REST_W-1:0] w_rest_d;

    lrpf_delay #(
        .W     (lrpf_pkg::REST_W),
        .DEPTH (ST_L - 1)
    ) u_rest_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r1_rest),
        .o_data (w_rest_d)
    );

    // force magnitude scale: ln ratio, times rest, times strength
    logic [lrpf_pkg::LG_W-1:0]  r_dlg;
    logic [lrpf_pkg::PL_W-1:0]  r_pl;
    logic [lrpf_pkg::L_W-1:0]   r_l;
    logic [lrpf_pkg::PG_W-1:0]  r_pg;
    logic [lrpf_pkg::G_W-1:0]   r_g;
    logic [lrpf_pkg::PH_W-1:0]  r_ph;
    logic [lrpf_pkg::H_W-1:0]   r_h;

    logic [lrpf_pkg::PL_W:0] w_l_sum;
    logic [lrpf_pkg::PG_W:0] w_g_sum;
    logic [lrpf_pkg::PH_W:0] w_h_sum;

    // round to nearest before each right shift
    assign w_l_sum = {1'b0, r_pl} +
                     ((lrpf_pkg::PL_W+1)'(1) << (lrpf_pkg::LN2_W - 1));
    assign w_g_sum = {1'b0, r_pg} +
                     ((lrpf_pkg::PG_W+1)'(1) << (lrpf_pkg::U_FRAC - 1));
    assign w_h_sum = {1'b0, r_ph} +
                     ((lrpf_pkg::PH_W+1)'(1) << (lrpf_pkg::STRENGTH_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dlg <= w_lg_r - w_lg_d;
            r_pl  <= lrpf_pkg::PL_W'(r_dlg) * lrpf_pkg::PL_W'(lrpf_pkg::LN2_HALF);
            r_l   <= w_l_sum[lrpf_pkg::LN2_W +: lrpf_pkg::L_W];
            r_pg  <= lrpf_pkg::PG_W'(w_rest_d) * lrpf_pkg::PG_W'(r_l);
            r_g   <= w_g_sum[lrpf_pkg::U_FRAC +: lrpf_pkg::G_W];
            r_ph  <= lrpf_pkg::PH_W'(r_g) * lrpf_pkg::PH_W'(r_strength);
            r_h   <= w_h_sum[lrpf_pkg::STRENGTH_FRAC +: lrpf_pkg::H_W];
        end
    end

    logic [lrpf_pkg::H_W-1:0] w_h_d;

    lrpf_delay #(
        .W     (lrpf_pkg::H_W),
        .DEPTH (ST_U - ST_H)
    ) u_h_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r_h),
        .o_data (w_h_d)
    );

    // per-axis unit vector component |delta| / d in Q.24
    logic [lrpf_pkg::U_W-1:0] w_u [NL];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        if (i < DIMENSIONS) begin : g_used
            logic [lrpf_pkg::MAG_W-1:0] w_mg_d;

            lrpf_delay #(
                .W     (lrpf_pkg::MAG_W),
                .DEPTH (ST_ROOT - 1)
            ) u_mg_dly (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_data (r1_mg[i]),
                .o_data (w_mg_d)
            );

            lrpf_div #(
                .N_W (lrpf_pkg::MAG_W),
                .D_W (lrpf_pkg::ROOT_W),
                .Q_W (lrpf_pkg::U_W),
                .SH  (lrpf_pkg::U_FRAC)
            ) u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (w_mg_d),
                .i_den (w_root),
                .o_quo (w_u[i])
            );
        end else begin : g_unused
            assign w_u[i] = '0;
        end
    end

    logic [NL-1:0] w_neg_d;

    lrpf_delay #(
        .W     (NL),
        .DEPTH (ST_MAG - 1)
    ) u_neg_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (r1_neg),
        .o_data (w_neg_d)
    );

    // component magnitude, H split so each factor taken from H stays within 32 bits
    logic [lrpf_pkg::PLO_W-1:0]  r_plo [NL];
    logic [lrpf_pkg::PHI_W-1:0]  r_phi [NL];
    logic [lrpf_pkg::UMAG_W-1:0] r_mag [NL];
    logic [lrpf_pkg::MS_W-1:0]   w_msum [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_msum[i] = lrpf_pkg::MS_W'(r_plo[i]) +
                        (lrpf_pkg::MS_W'(r_phi[i]) << lrpf_pkg::FORCE_W) +
                        (lrpf_pkg::MS_W'(1) << (lrpf_pkg::U_FRAC - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NL; i++) begin
                r_plo[i] <= lrpf_pkg::PLO_W'(w_h_d[lrpf_pkg::FORCE_W-1:0]) *
                            lrpf_pkg::PLO_W'(w_u[i]);
                r_phi[i] <= lrpf_pkg::PHI_W'(w_h_d[lrpf_pkg::H_W-1:lrpf_pkg::FORCE_W]) *
                            lrpf_pkg::PHI_W'(w_u[i]);
                r_mag[i] <= w_msum[i][lrpf_pkg::U_FRAC +: lrpf_pkg::UMAG_W];
            end
        end
    end

    // saturate, point the force away from B, gate by status
    localparam logic [lrpf_pkg::UMAG_W-1:0] POS_MAX =
        (lrpf_pkg::UMAG_W'(1) << (lrpf_pkg::FORCE_W - 1)) - 1'b1;
    localparam logic [lrpf_pkg::UMAG_W-1:0] NEG_MAX =
        lrpf_pkg::UMAG_W'(1) << (lrpf_pkg::FORCE_W - 1);

    logic [lrpf_pkg::FORCE_W-1:0] w_force [NL];
    lrpf_pkg::t_status            w_status;
    lrpf_pkg::t_pair_force        w_fin;
    logic                         w_fin_valid;

    always_comb begin
        priority if (w_flags_end.no_overlap) begin
            w_status = lrpf_pkg::ST_NO_OVERLAP;
        end else if (w_flags_end.coincident) begin
            w_status = lrpf_pkg::ST_COINCIDENT;
        end else begin
            w_status = lrpf_pkg::ST_REPULSION;
        end

        for (int i = 0; i < NL; i++) begin
            if (w_status != lrpf_pkg::ST_REPULSION) begin
                w_force[i] = '0;
            end else if (w_neg_d[i]) begin
                w_force[i] = (r_mag[i] > POS_MAX) ? POS_MAX[lrpf_pkg::FORCE_W-1:0] :
                                                    r_mag[i][lrpf_pkg::FORCE_W-1:0];
            end else begin
                w_force[i] = '0 - ((r_mag[i] > NEG_MAX) ? NEG_MAX[lrpf_pkg::FORCE_W-1:0] :
                                                         r_mag[i][lrpf_pkg::FORCE_W-1:0]);
            end
        end

        w_fin.force_x        = w_force[0];
        w_fin.force_y        = w_force[1];
        w_fin.force_z        = w_force[2];
        w_fin.contact_status = w_status;
    end

    assign w_fin_valid = r_valid[NSTG-1];

    // output register with one skid entry
    lrpf_pkg::t_pair_force r_out;
    lrpf_pkg::t_pair_force r_skid;
    logic                  r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                // pipeline is frozen, drain the skid entry first
                if (i_rsp_ready) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end
            end else if (w_fin_valid) begin
                if (!r_out_v || i_rsp_ready) begin
                    r_out   <= w_fin;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid   <= w_fin;
                    r_skid_v <= 1'b1;
                end
            end else if (i_rsp_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_v;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

@@ design/lrpf_checker.sv @@
// port-level checks for the log repulsion pair force core, bound to the top level
// uses lrpf_pkg for the result type and status codes
`default_nettype none

module lrpf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_req_ready,
    input logic                  o_rsp_valid,
    input logic                  i_rsp_ready,
    input lrpf_pkg::t_pair_force o_rsp
);

    // reset empties the result side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // requests are refused only while a result is waiting
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> o_rsp_valid)
        else $error("request side stalled with no result pending");

    // no force unless repulsion applied
    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.contact_status != lrpf_pkg::ST_REPULSION |->
            o_rsp.force_x == '0 && o_rsp.force_y == '0 && o_rsp.force_z == '0)
        else $error("force without repulsion status");

endmodule

bind log_repulsion_pair_force_core lrpf_checker u_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// self-checking bench for log_repulsion_pair_force_core: directed table, then random pairs
// depends on lrpf_pkg and the core; predicts forces with its own fixed point model
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY = 55;
    localparam int N_RANDOM = 440;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    lrpf_pkg::t_pair_req i_req = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    lrpf_pkg::t_pair_force o_rsp;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [lrpf_pkg::STRENGTH_W-1:0] i_cfg_data = '0;

    // model copy of the strength register
    logic [lrpf_pkg::STRENGTH_W-1:0] strength_q = lrpf_pkg::STRENGTH_RESET;
    lrpf_pkg::t_pair_force force_fifo[$];
    int n_errors = 0;
    bit req_done = 1'b0;

    always #1 i_clk = ~i_clk;

    log_repulsion_pair_force_core #(.DIMENSIONS(3)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q.24: integer part from msb position, fraction by repeated squaring
    function automatic longint unsigned log2_q24(longint unsigned v);
        int p;
        longint unsigned m, f;
        p = 63;
        f = 0;
        while (p > 0 && v[p] == 1'b0) p--;
        m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                f = f | 1;
            end
        end
        return (64'(p) << 24) | f;
    endfunction

    function automatic lrpf_pkg::t_pair_force pair_force(lrpf_pkg::t_pair_req rq,
                                                         logic [lrpf_pkg::STRENGTH_W-1:0] k);
        lrpf_pkg::t_pair_force res;
        longint signed dl[3];
        longint unsigned mg[3], fo[3];
        longint unsigned d2, rest, r2, d, dlog, lnv, g, h, u, mag;
        dl[0] = rq.delta_x;
        dl[1] = rq.delta_y;
        dl[2] = rq.delta_z;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (dl[i] < 0) ? -dl[i] : dl[i];
            d2 += mg[i] * mg[i];
            fo[i] = 0;
        end
        rest = rq.radius_a + rq.radius_b;
        r2 = rest * rest;
        res = '0;
        if (d2 >= r2) begin
            res.contact_status = lrpf_pkg::ST_NO_OVERLAP;
            return res;
        end
        if (d2 == 0) begin
            res.contact_status = lrpf_pkg::ST_COINCIDENT;
            return res;
        end
        d = floor_sqrt(d2);
        dlog = log2_q24(r2) - log2_q24(d2);
        // dlog < 2^30 and the constant < 2^31, so the product fits 64 bits
        lnv = (dlog * 64'd1488522236 + (64'd1 << 31)) >> 32;
        g = (rest * lnv + (64'd1 << 23)) >> 24;
        h = (g * k + (64'd1 << 15)) >> 16;
        for (int i = 0; i < 3; i++) begin
            if (dl[i] != 0) begin
                u = (mg[i] << 24) / d;
                mag = (h * u + (64'd1 << 23)) >> 24;
                if (dl[i] > 0) begin
                    if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
                    fo[i] = ((64'd1 << 32) - mag) & 64'hFFFF_FFFF;
                end else begin
                    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
                    fo[i] = mag;
                end
            end
        end
        res.force_x = fo[0][31:0];
        res.force_y = fo[1][31:0];
        res.force_z = fo[2][31:0];
        res.contact_status = lrpf_pkg::ST_REPULSION;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // valid drops only when a gap follows, so back-to-back requests keep it high
    task automatic send_pair(lrpf_pkg::t_pair_req rq, bit typed, lrpf_pkg::t_pair_force want);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        force_fifo.push_back(typed ? want : pair_force(rq, strength_q));
        i_req <= rq;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    // wait for all results to drain, then write the strength register
    task automatic write_strength(logic [lrpf_pkg::STRENGTH_W-1:0] v);
        i_req_valid <= 1'b0;
        while (force_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        strength_q = v;
    endtask

    function automatic lrpf_pkg::t_pair_req mk(int dx, int dy, int dz, int ra, int rb);
        lrpf_pkg::t_pair_req r;
        r.delta_x = dx[23:0];
        r.delta_y = dy[23:0];
        r.delta_z = dz[23:0];
        r.radius_a = ra[19:0];
        r.radius_b = rb[19:0];
        return r;
    endfunction

    function automatic lrpf_pkg::t_pair_req rand_pair();
        lrpf_pkg::t_pair_req r;
        int sel;
        r.radius_a = lrpf_pkg::RADIUS_W'($urandom_range(0, 20'hFFFFF));
        r.radius_b = lrpf_pkg::RADIUS_W'($urandom_range(0, 20'hFFFFF));
        sel = $urandom_range(0, 9);
        // mostly overlapping pairs: components scaled below the rest length
        if (sel < 7) begin
            int lim;
            lim = (r.radius_a + r.radius_b) / 2;
            if (sel == 0) lim = 1 + (lim >> 8);
            r.delta_x = lrpf_pkg::DELTA_W'($urandom_range(0, 2 * lim) - lim);
            r.delta_y = lrpf_pkg::DELTA_W'($urandom_range(0, 2 * lim) - lim);
            r.delta_z = lrpf_pkg::DELTA_W'($urandom_range(0, 2 * lim) - lim);
        end else begin
            r.delta_x = lrpf_pkg::DELTA_W'($urandom());
            r.delta_y = lrpf_pkg::DELTA_W'($urandom());
            r.delta_z = lrpf_pkg::DELTA_W'($urandom());
        end
        if ($urandom_range(0, 7) == 0) r.delta_y = '0;
        if ($urandom_range(0, 7) == 0) r.delta_z = '0;
        return r;
    endfunction

    // result side: random stall per result, compare against oldest expectation
    initial begin
        lrpf_pkg::t_pair_force want;
        int stall;
        @(posedge i_clk);
        while (i_rst_n == 1'b0) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
            if (force_fifo.size() == 0) begin
                report_mismatch("unexpected result", o_rsp.contact_status, -1);
            end else begin
                want = force_fifo.pop_front();
                if (o_rsp.force_x !== want.force_x)
                    report_mismatch("force_x", o_rsp.force_x, want.force_x);
                if (o_rsp.force_y !== want.force_y)
                    report_mismatch("force_y", o_rsp.force_y, want.force_y);
                if (o_rsp.force_z !== want.force_z)
                    report_mismatch("force_z", o_rsp.force_z, want.force_z);
                if (o_rsp.contact_status !== want.contact_status)
                    report_mismatch("status", o_rsp.contact_status, want.contact_status);
            end
        end
    end

    // directed table; typed expectations only where obvious
    typedef struct {
        lrpf_pkg::t_pair_req rq;
        bit typed;
        lrpf_pkg::t_pair_force want;
    } t_row;

    initial begin
        t_row rows[$];
        lrpf_pkg::t_pair_force zero_no, zero_co;
        logic [lrpf_pkg::STRENGTH_W-1:0] k_list[5];
        zero_no = '0;
        zero_no.contact_status = lrpf_pkg::ST_NO_OVERLAP;
        zero_co = '0;
        zero_co.contact_status = lrpf_pkg::ST_COINCIDENT;
        // zero rest length, beyond rest, coincident centres
        rows.push_back('{mk(0, 0, 0, 0, 0), 1, zero_no});
        rows.push_back('{mk(65536, 0, 0, 0, 0), 1, zero_no});
        rows.push_back('{mk(0, 0, 0, 65536, 65536), 1, zero_co});
        rows.push_back('{mk(0, 0, 0, 1048575, 1048575), 1, zero_co});
        rows.push_back('{mk(131072, 0, 0, 65536, 65536), 1, zero_no});
        rows.push_back('{mk(-8388608, -8388608, -8388608, 1048575, 1048575), 1, zero_no});
        rows.push_back('{mk(8388607, 8388607, 8388607, 1048575, 1048575), 1, zero_no});
        // overlaps checked by the predictor, signs and extremes
        rows.push_back('{mk(65536, 0, 0, 65536, 65536), 0, zero_no});
        rows.push_back('{mk(-65536, 0, 0, 65536, 65536), 0, zero_no});
        rows.push_back('{mk(0, 1, 0, 1048575, 1048575), 0, zero_no});
        rows.push_back('{mk(0, 0, -1, 1048575, 1048575), 0, zero_no});
        rows.push_back('{mk(1, -1, 1, 1048575, 1048575), 0, zero_no});
        rows.push_back('{mk(1000000, -900000, 500000, 1048575, 1048575), 0, zero_no});
        rows.push_back('{mk(131071, 0, 0, 65536, 65536), 0, zero_no});
        rows.push_back('{mk(3, 0, 0, 1, 1), 0, zero_no});
        rows.push_back('{mk(1, 0, 0, 1, 1), 0, zero_no});
        rows.push_back('{mk(-1, 0, 0, 0, 2), 0, zero_no});

        k_list = '{24'd1, 24'hFFFFFF, 24'd1966080, 24'd0, 24'd983040};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_pair(rows[i].rq, rows[i].typed, rows[i].want);
        // strength extremes, including out-of-range zero, then back to reset value
        foreach (k_list[j]) begin
            write_strength(k_list[j]);
            foreach (rows[i]) if (!rows[i].typed) send_pair(rows[i].rq, 0, zero_no);
            for (int n = 0; n < 40; n++) send_pair(rand_pair(), 0, zero_no);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 100)
                write_strength(lrpf_pkg::STRENGTH_W'($urandom_range(1, 24'hFFFFFF)));
            send_pair(rand_pair(), 0, zero_no);
        end
        i_req_valid <= 1'b0;
        req_done = 1'b1;
    end

    // end of run
    initial begin
        wait (req_done);
        while (force_fifo.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/lrpf_pkg.sv
design/lrpf_delay.sv
design/lrpf_isqrt.sv
design/lrpf_log2.sv
design/lrpf_div.sv
design/log_repulsion_pair_force_core.sv
design/lrpf_checker.sv
dv/testbench.sv
